FILE: sv/ratu_pkg.sv
// ----------------------------------------------------------------------------
// ratu_pkg
// Shared types and constants for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package ratu_pkg;

   localparam int DEF_OPERAND_WIDTH = 32;
   localparam int WIDE_W            = 64;
   localparam int DEN_W             = 63;
   localparam int SHIFT_W           = 7;
   localparam int DIV_CNT_W         = 6;

   localparam logic [WIDE_W-1:0] MAX_POS = {1'b0, {(WIDE_W-1){1'b1}}};

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } ratu_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_START,
      ST_REDUCE,
      ST_RESP
   } ratu_state_type;

   typedef enum logic [1:0] {
      RD_IDLE,
      RD_GCD,
      RD_DIV,
      RD_DONE
   } ratu_rd_state_type;

endpackage

FILE: sv/ratu_reduce.sv
// ----------------------------------------------------------------------------
// ratu_reduce
// Reduces a fraction by its gcd: binary gcd one step a cycle, then a
// two-lane restoring divider (one quotient bit a cycle) for both terms.
// ----------------------------------------------------------------------------
module ratu_reduce
   import ratu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WIDE_W-1:0] num_mag,
   input  logic [WIDE_W-1:0] den_mag,
   output logic [WIDE_W-1:0] num_red,
   output logic [WIDE_W-1:0] den_red,
   output logic              done
);

   ratu_rd_state_type state_ff, state_in;

   logic [WIDE_W-1:0]    x_ff, x_in, y_ff, y_in;
   logic [SHIFT_W-1:0]   k_ff, k_in;
   logic [WIDE_W-1:0]    g_ff, g_in;
   logic [WIDE_W-1:0]    qn_ff, qn_in, qd_ff, qd_in;
   logic [WIDE_W-1:0]    rn_ff, rn_in, rd_ff, rd_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDE_W-1:0]    rn_try, rd_try;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         RD_IDLE: if (start) state_in = RD_GCD;
         RD_GCD:  if (x_ff == '0) state_in = RD_DIV;
         RD_DIV:  if (cnt_ff == '1) state_in = RD_DONE;
         RD_DONE: state_in = RD_IDLE;
         default: state_in = RD_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      done    = (state_ff == RD_DONE);
      num_red = qn_ff;
      den_red = qd_ff;
   end

   // shared datapath: gcd step or divide step
   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      k_in   = k_ff;
      g_in   = g_ff;
      qn_in  = qn_ff;
      qd_in  = qd_ff;
      rn_in  = rn_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      rn_try = {rn_ff[WIDE_W-2:0], qn_ff[WIDE_W-1]};
      rd_try = {rd_ff[WIDE_W-2:0], qd_ff[WIDE_W-1]};
      unique case (state_ff)
         RD_IDLE: begin
            x_in  = num_mag;
            y_in  = den_mag;
            k_in  = '0;
            qn_in = num_mag;
            qd_in = den_mag;
         end
         RD_GCD: begin
            rn_in  = '0;
            rd_in  = '0;
            cnt_in = '0;
            priority if (x_ff == '0) begin
               g_in = y_ff << k_ff;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (x_ff >= y_ff) begin
               // difference of two odd values is even
               x_in = (x_ff - y_ff) >> 1;
            end else begin
               y_in = (y_ff - x_ff) >> 1;
            end
         end
         RD_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (rn_try >= g_ff) begin
               rn_in = rn_try - g_ff;
               qn_in = {qn_ff[WIDE_W-2:0], 1'b1};
            end else begin
               rn_in = rn_try;
               qn_in = {qn_ff[WIDE_W-2:0], 1'b0};
            end
            if (rd_try >= g_ff) begin
               rd_in = rd_try - g_ff;
               qd_in = {qd_ff[WIDE_W-2:0], 1'b1};
            end else begin
               rd_in = rd_try;
               qd_in = {qd_ff[WIDE_W-2:0], 1'b0};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RD_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      k_ff   <= k_in;
      g_ff   <= g_in;
      qn_ff  <= qn_in;
      qd_ff  <= qd_in;
      rn_ff  <= rn_in;
      rd_ff  <= rd_in;
      cnt_ff <= cnt_in;
   end

endmodule

FILE: sv/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Adds, subtracts, multiplies or divides two signed fractions and returns
// the result in lowest terms with a positive denominator.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req       in         req_valid/req_stall  cmd, a_num, a_den, b_num, b_den
//  rsp       out        rsp_valid/rsp_stall  res_num, res_den, den_forced
//
// One request at a time: the shared multiplier forms three products, then a sum
// state, a start state, the binary gcd steps and 64 divide steps; the
// response then waits in its output register.
// req_stall is high from accept until the response is taken.
// Synchronous active-high reset returns both sequencers to idle.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
   import ratu_pkg::*;
#(
   parameter int OPERAND_WIDTH = DEF_OPERAND_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_cmd,
   input  logic signed [OPERAND_WIDTH-1:0] req_a_num,
   input  logic signed [OPERAND_WIDTH-1:0] req_a_den,
   input  logic signed [OPERAND_WIDTH-1:0] req_b_num,
   input  logic signed [OPERAND_WIDTH-1:0] req_b_den,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [WIDE_W-1:0]        rsp_res_num,
   output logic [DEN_W-1:0]                rsp_res_den,
   output logic                            rsp_den_forced
);

   localparam int W = OPERAND_WIDTH;

   ratu_state_type state_ff, state_in;
   ratu_op_type    op_ff;

   logic [W-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic         an_neg_ff, ad_neg_ff, bn_neg_ff, bd_neg_ff;
   logic [1:0]   mcnt_ff;

   logic [WIDE_W-1:0] t1_ff, t2_ff, dp_ff;
   logic              t1_neg_ff, t2_neg_ff, dp_neg_ff;

   logic [WIDE_W-1:0] num_ff, num_in, den_ff, den_in;
   logic              num_neg_ff, num_neg_in, den_neg_ff, den_neg_in;
   logic              forced_ff, forced_in;

   logic [WIDE_W-1:0] res_num_ff, res_num_in;
   logic [DEN_W-1:0]  res_den_ff, res_den_in;

   logic [W-1:0]      mul_a, mul_b;
   logic              mul_neg;
   logic [2*W-1:0]    prod;
   logic [WIDE_W-1:0] prod_w;
   logic              t1_s, t2_s;
   logic              start, red_done, res_neg;
   logic [WIDE_W-1:0] num_red, den_red;

   function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
      mag_of = v[W-1] ? (~v + 1'b1) : v;
   endfunction

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_MUL;
         ST_MUL:    if (mcnt_ff == 2'd2) state_in = ST_SUM;
         ST_SUM:    state_in = ST_START;
         ST_START:  state_in = ST_REDUCE;
         ST_REDUCE: if (red_done) state_in = ST_RESP;
         ST_RESP:   if (!rsp_stall) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall      = (state_ff != ST_IDLE);
      rsp_valid      = (state_ff == ST_RESP);
      start          = (state_ff == ST_START);
      rsp_res_num    = res_num_ff;
      rsp_res_den    = res_den_ff;
      rsp_den_forced = forced_ff;
   end

   // shared multiplier operand select
   always_comb begin
      unique case (mcnt_ff)
         2'd0: begin
            mul_a   = an_ff;
            mul_b   = (op_ff == OP_MUL) ? bn_ff : bd_ff;
            mul_neg = an_neg_ff ^ ((op_ff == OP_MUL) ? bn_neg_ff : bd_neg_ff);
         end
         2'd1: begin
            mul_a   = ad_ff;
            mul_b   = bn_ff;
            mul_neg = ad_neg_ff ^ bn_neg_ff;
         end
         default: begin
            mul_a   = ad_ff;
            mul_b   = (op_ff == OP_DIV) ? bn_ff : bd_ff;
            mul_neg = ad_neg_ff ^ ((op_ff == OP_DIV) ? bn_neg_ff : bd_neg_ff);
         end
      endcase
      prod   = mul_a * mul_b;
      prod_w = WIDE_W'(prod);
   end

   // signed-magnitude combine of the cross products
   always_comb begin
      t1_s       = (t1_ff != '0) && t1_neg_ff;
      t2_s       = (t2_ff != '0) && (t2_neg_ff ^ (op_ff == OP_SUB));
      num_in     = t1_ff;
      num_neg_in = t1_s;
      if (op_ff == OP_ADD || op_ff == OP_SUB) begin
         priority if (t1_s == t2_s) begin
            num_in     = t1_ff + t2_ff;
            num_neg_in = t1_s;
         end else if (t1_ff >= t2_ff) begin
            num_in     = t1_ff - t2_ff;
            num_neg_in = t1_s;
         end else begin
            num_in     = t2_ff - t1_ff;
            num_neg_in = t2_s;
         end
      end
      if (num_in == '0) num_neg_in = 1'b0;
      // zero denominator is forced to one
      forced_in  = (dp_ff == '0);
      den_in     = forced_in ? WIDE_W'(1) : dp_ff;
      den_neg_in = !forced_in && dp_neg_ff;
   end

   // final sign, saturation and zero handling
   always_comb begin
      res_neg = (num_red != '0) && (num_neg_ff != den_neg_ff);
      if (res_neg) begin
         res_num_in = ~num_red + 1'b1;
      end else begin
         res_num_in = num_red[WIDE_W-1] ? MAX_POS : num_red;
      end
      res_den_in = (num_red == '0) ? DEN_W'(1) : den_red[DEN_W-1:0];
   end

   ratu_reduce u_reduce (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .num_mag (num_ff),
      .den_mag (den_ff),
      .num_red (num_red),
      .den_red (den_red),
      .done    (red_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_MUL) mcnt_ff <= mcnt_ff + 1'b1;
         else                    mcnt_ff <= '0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         op_ff     <= ratu_op_type'(req_cmd);
         an_ff     <= mag_of(req_a_num);
         ad_ff     <= mag_of(req_a_den);
         bn_ff     <= mag_of(req_b_num);
         bd_ff     <= mag_of(req_b_den);
         an_neg_ff <= req_a_num[W-1];
         ad_neg_ff <= req_a_den[W-1];
         bn_neg_ff <= req_b_num[W-1];
         bd_neg_ff <= req_b_den[W-1];
      end
      if (state_ff == ST_MUL) begin
         unique case (mcnt_ff)
            2'd0:    begin t1_ff <= prod_w; t1_neg_ff <= mul_neg; end
            2'd1:    begin t2_ff <= prod_w; t2_neg_ff <= mul_neg; end
            default: begin dp_ff <= prod_w; dp_neg_ff <= mul_neg; end
         endcase
      end
      if (state_ff == ST_SUM) begin
         num_ff     <= num_in;
         num_neg_ff <= num_neg_in;
         den_ff     <= den_in;
         den_neg_ff <= den_neg_in;
         forced_ff  <= forced_in;
      end
      if (state_ff == ST_REDUCE && red_done) begin
         res_num_ff <= res_num_in;
         res_den_ff <= res_den_in;
      end
   end

endmodule

FILE: sv/ratu_checker.sv
// ----------------------------------------------------------------------------
// ratu_checker
// Port-level checks on the rational arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module ratu_checker
   import ratu_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [WIDE_W-1:0]  rsp_res_num,
   input logic [DEN_W-1:0]   rsp_res_den
);

   // denominator is never zero
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_res_den != '0))
      else $error("zero result denominator");

   // zero comes out as 0/1
   a_zero_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_res_num == '0) |-> (rsp_res_den == DEN_W'(1)))
      else $error("zero result not 0/1");

   // one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request taken while busy");

   // no new request while a response is pending
   a_stall_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request path open during response");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_res_num)))
      else $error("stalled response changed");

endmodule

bind rational_arithmetic_unit ratu_checker u_ratu_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_res_num (rsp_res_num),
   .rsp_res_den (rsp_res_den)
);

FILE: dv/rational_arithmetic_unit_checker.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_checker
// Watches the request and response channels, computes the reduced fraction
// for every accepted request and compares each response field by field.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_checker
   import ratu_pkg::*;
#(
   parameter int OPERAND_WIDTH = DEF_OPERAND_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [1:0]                      req_cmd,
   input  logic signed [OPERAND_WIDTH-1:0] req_a_num,
   input  logic signed [OPERAND_WIDTH-1:0] req_a_den,
   input  logic signed [OPERAND_WIDTH-1:0] req_b_num,
   input  logic signed [OPERAND_WIDTH-1:0] req_b_den,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic signed [WIDE_W-1:0]        rsp_res_num,
   input  logic [DEN_W-1:0]                rsp_res_den,
   input  logic                            rsp_den_forced,
   output int                              fail_count,
   output int                              pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [WIDE_W-1:0] num;
      logic [DEN_W-1:0]  den;
      logic              forced;
   } fraction_type;

   fraction_type reduced_q[$];

   // magnitude of a signed operand field, widened
   function automatic logic [WIDE_W-1:0] magnitude(logic [OPERAND_WIDTH-1:0] v);
      logic [OPERAND_WIDTH-1:0] nv;
      nv = ~v + 1'b1;
      return v[OPERAND_WIDTH-1] ? WIDE_W'(nv) : WIDE_W'(v);
   endfunction

   // signed sum of two sign-magnitude values
   function automatic void sm_sum(input logic xn, input logic [WIDE_W-1:0] xm,
                                  input logic yn, input logic [WIDE_W-1:0] ym,
                                  output logic rn, output logic [WIDE_W-1:0] rm);
      if (xn == yn) begin
         rm = xm + ym; rn = xn;
      end else if (xm >= ym) begin
         rm = xm - ym; rn = xn;
      end else begin
         rm = ym - xm; rn = yn;
      end
      if (rm == 0) rn = 1'b0;
   endfunction

   function automatic fraction_type reduce_fraction(ratu_op_type op,
         logic [OPERAND_WIDTH-1:0] an, logic [OPERAND_WIDTH-1:0] ad,
         logic [OPERAND_WIDTH-1:0] bn, logic [OPERAND_WIDTH-1:0] bd);
      fraction_type f;
      logic [WIDE_W-1:0] anm, adm, bnm, bdm, nm, dm, p1, p2, x, y, t;
      logic ans, ads, bns, bds, nn, dn, p1n, p2n, neg;
      anm = magnitude(an); ans = an[OPERAND_WIDTH-1];
      adm = magnitude(ad); ads = ad[OPERAND_WIDTH-1];
      bnm = magnitude(bn); bns = bn[OPERAND_WIDTH-1];
      bdm = magnitude(bd); bds = bd[OPERAND_WIDTH-1];
      case (op)
         OP_ADD, OP_SUB: begin
            p1 = anm * bdm; p1n = (p1 != 0) && (ans != bds);
            p2 = adm * bnm; p2n = (p2 != 0) && (ads != bns);
            if (op == OP_SUB) p2n = (p2 != 0) && !p2n;
            sm_sum(p1n, p1, p2n, p2, nn, nm);
            dm = adm * bdm; dn = (dm != 0) && (ads != bds);
         end
         OP_MUL: begin
            nm = anm * bnm; nn = (nm != 0) && (ans != bns);
            dm = adm * bdm; dn = (dm != 0) && (ads != bds);
         end
         default: begin
            nm = anm * bdm; nn = (nm != 0) && (ans != bds);
            dm = adm * bnm; dn = (dm != 0) && (ads != bns);
         end
      endcase
      f.forced = (dm == 0);
      if (dm == 0) begin
         dm = 1; dn = 1'b0;
      end
      // Euclid
      x = nm; y = dm;
      while (y != 0) begin
         t = x % y; x = y; y = t;
      end
      nm = nm / x; dm = dm / x;
      neg = (nm != 0) && (nn != dn);
      if (nm == 0) dm = 1;
      if (neg) f.num = -nm;
      else f.num = (nm > MAX_POS) ? MAX_POS : nm;
      f.den = dm[DEN_W-1:0];
      return f;
   endfunction

   assign pending_count = reduced_q.size();

   always @(posedge clock) begin
      fraction_type e;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            reduced_q.push_back(reduce_fraction(ratu_op_type'(req_cmd), req_a_num,
               req_a_den, req_b_num, req_b_den));
         if (rsp_valid && !rsp_stall) begin
            if (reduced_q.size() == 0) begin
               $error("response with no request outstanding");
               fail_count <= fail_count + 1;
            end else begin
               e = reduced_q.pop_front();
               if (rsp_res_num !== e.num || rsp_res_den !== e.den ||
                     rsp_den_forced !== e.forced) begin
                  fail_count <= fail_count + 1;
                  if (rsp_res_num !== e.num)
                     $error("res_num expected %0d actual %0d", $signed(e.num),
                        rsp_res_num);
                  if (rsp_res_den !== e.den)
                     $error("res_den expected %0d actual %0d", e.den, rsp_res_den);
                  if (rsp_den_forced !== e.forced)
                     $error("den_forced expected %0b actual %0b", e.forced,
                        rsp_den_forced);
               end
            end
         end
      end
   end

endmodule

FILE: dv/rational_arithmetic_unit_test.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_test
// Drives directed and random fraction requests with random idle and stall
// patterns; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_test;
   import ratu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W = DEF_OPERAND_WIDTH;
   localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_cmd = OP_ADD;
   logic signed [W-1:0] req_a_num = '0, req_a_den = '0, req_b_num = '0, req_b_den = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [WIDE_W-1:0] rsp_res_num;
   logic [DEN_W-1:0] rsp_res_den;
   logic rsp_den_forced;
   int fail_count, pending_count;
   int send_idle_pct = 6, recv_stall_pct = 52;

   always #4 clock = ~clock;

   rational_arithmetic_unit #(.OPERAND_WIDTH(W)) DUT (.*);
   rational_arithmetic_unit_checker #(.OPERAND_WIDTH(W)) checker_inst (.*);

   // receiver stalls at random
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   // random operand: mostly small, sometimes full width or extremes
   function automatic logic [W-1:0] pick_operand();
      case ($urandom_range(9))
         0: return MOST_NEG;
         1: return MOST_POS;
         2: return '0;
         3, 4: return W'($urandom);
         default: return W'($signed($urandom_range(200)) - 100);
      endcase
   endfunction

   // valid stays high after an accept unless the sender idles
   task automatic send_request(ratu_op_type op, logic [W-1:0] an, logic [W-1:0] ad,
                               logic [W-1:0] bn, logic [W-1:0] bd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= op;
      req_a_num <= an; req_a_den <= ad; req_b_num <= bn; req_b_den <= bd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_random(int n);
      logic [W-1:0] an, ad, bn, bd;
      for (int i = 0; i < n; i++) begin
         an = pick_operand(); ad = pick_operand();
         bn = pick_operand(); bd = pick_operand();
         // keep most denominators nonzero
         if (ad == 0 && $urandom_range(3) != 0) ad = 1;
         if (bd == 0 && $urandom_range(3) != 0) bd = 7;
         send_request(ratu_op_type'($urandom_range(3)), an, ad, bn, bd);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: every op, extremes, zero denominators and numerators
      send_request(OP_ADD, 1, 2, 1, 3);
      send_request(OP_SUB, 1, 2, 1, 2);
      send_request(OP_MUL, -2, 4, 3, -9);
      send_request(OP_DIV, 3, 4, 0, 5);
      send_request(OP_DIV, 0, 4, 0, 5);
      send_request(OP_ADD, 5, 0, 3, 7);
      send_request(OP_MUL, 0, 0, 3, 7);
      send_request(OP_ADD, MOST_NEG, 1, MOST_NEG, 1);
      send_request(OP_ADD, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG);
      send_request(OP_SUB, MOST_NEG, MOST_NEG, MOST_POS, MOST_NEG);
      send_request(OP_ADD, MOST_NEG, MOST_NEG, MOST_NEG, 1);
      send_request(OP_SUB, MOST_POS, MOST_NEG, MOST_NEG, MOST_NEG);
      send_request(OP_MUL, MOST_POS, MOST_POS, MOST_NEG, MOST_NEG);
      send_request(OP_DIV, MOST_NEG, MOST_POS, MOST_NEG, MOST_POS);
      send_request(OP_MUL, 32'hFFFF_FFFF, 32'hAAAA_5555, 32'h5555_AAAA, -1);
      send_request(OP_DIV, 32'h1234_5678, 32'h8765_4321, -7, 32'h7FFF_0001);
      req_valid <= 1'b0;
      // hold off until the unit has drained
      while (pending_count != 0) @(posedge clock);
      send_random(250);
      send_idle_pct = 52; recv_stall_pct = 6;
      send_random(250);
      send_idle_pct = 0; recv_stall_pct = 0;
      send_random(250);
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (250) @(posedge clock);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #10ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
